[rtl/alu16_pkg.sv]
`default_nettype none

package alu16_pkg;

	localparam int DATA_W = 16;
	localparam int FUNC_W = 5;
	localparam int IMM_W  = 8;
	localparam int SHAMT_W = 4;

	// opcodes, anything else leaves the state untouched
	typedef enum logic [FUNC_W-1:0] {
		OP_ADD  = 5'd1,
		OP_ADDI = 5'd2,
		OP_SUB  = 5'd3,
		OP_SUBI = 5'd4,
		OP_CMP  = 5'd5,
		OP_CMPI = 5'd6,
		OP_AND  = 5'd7,
		OP_ANDI = 5'd8,
		OP_OR   = 5'd9,
		OP_ORI  = 5'd10,
		OP_XOR  = 5'd11,
		OP_XORI = 5'd12,
		OP_MOV  = 5'd13,
		OP_MOVI = 5'd14,
		OP_LSH  = 5'd15,
		OP_LSHI = 5'd16,
		OP_ASH  = 5'd17,
		OP_ASHI = 5'd18,
		OP_LUI  = 5'd19,
		OP_LOAD = 5'd20,
		OP_STOR = 5'd21,
		OP_NOP  = 5'd22
	} op_t;

	// status bits, carry in bit 0 up to zero in bit 3
	typedef struct packed {
		logic zero;
		logic overflow;
		logic borrow;
		logic carry;
	} flags_t;

	// architectural state after one operation
	typedef struct packed {
		logic [DATA_W-1:0] result;
		flags_t            flags;
	} alu_state_t;

endpackage

`default_nettype wire

[rtl/alu16_exec.sv]
`default_nettype none

module alu16_exec
	import alu16_pkg::*;
(
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [DATA_W-1:0] operand_a,
	input  wire logic [DATA_W-1:0] operand_b,
	input  wire logic [IMM_W-1:0]  imm_byte,
	input  wire alu_state_t        cur,
	output alu_state_t             nxt
);

	// fill every bit below the highest set bit
	function automatic logic [DATA_W-1:0] smear(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] s;
		s = v;
		s = s | (s >> 1);
		s = s | (s >> 2);
		s = s | (s >> 4);
		s = s | (s >> 8);
		return s;
	endfunction

	logic [DATA_W-1:0] imm_s;
	logic [DATA_W-1:0] imm_z;
	logic [DATA_W-1:0] arith_x;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] add_out;
	logic [DATA_W-1:0] add_mask;
	flags_t            add_flags;
	logic              sub_ok;
	logic [DATA_W-1:0] sub_out;
	logic [DATA_W-1:0] sub_mask;
	flags_t            sub_flags;
	logic [DATA_W-1:0] neg_b;
	logic [DATA_W-1:0] reg_cnt;
	logic              reg_right;
	logic              reg_big;
	logic              use_shi;
	logic [SHAMT_W-1:0] sh_amt;
	logic              sh_right;
	logic              sh_big;
	logic [DATA_W-1:0] shl_out;
	logic [DATA_W-1:0] shr_out;
	logic [DATA_W-1:0] sar_out;
	logic [DATA_W-1:0] fill;
	logic              use_imm;

	// immediate forms
	assign imm_s = {{(DATA_W-IMM_W){imm_byte[IMM_W-1]}}, imm_byte};
	assign imm_z = {{(DATA_W-IMM_W){1'b0}}, imm_byte};

	assign use_imm = (func == OP_ADDI) || (func == OP_SUBI) || (func == OP_CMPI);
	assign arith_x = use_imm ? imm_s : operand_b;

	// add with saturate-to-zero on overflow
	assign sum      = {1'b0, operand_a} + {1'b0, arith_x};
	assign add_out  = sum[DATA_W] ? '0 : sum[DATA_W-1:0];
	assign add_mask = smear(operand_a | arith_x);
	always_comb begin
		add_flags.carry    = |(add_out & ~add_mask);
		add_flags.borrow   = 1'b0;
		add_flags.overflow = sum[DATA_W];
		add_flags.zero     = (add_out == '0);
	end

	// subtract, clamps to zero on underflow
	assign sub_ok   = (operand_a >= arith_x);
	assign sub_out  = sub_ok ? (operand_a - arith_x) : '0;
	assign sub_mask = smear(operand_a | arith_x) >> 1;
	always_comb begin
		if (sub_ok) begin
			sub_flags.carry    = ((operand_a | arith_x) != '0) && ((sub_out & ~sub_mask) == '0);
			sub_flags.borrow   = 1'b0;
			sub_flags.overflow = 1'b0;
		end else begin
			sub_flags.carry    = 1'b1;
			sub_flags.borrow   = 1'b1;
			sub_flags.overflow = 1'b1;
		end
		sub_flags.zero = (sub_out == '0);
	end

	// shift count: register form is signed, immediate form has a direction bit
	assign neg_b     = ~operand_b + 1'b1;
	assign reg_right = operand_b[DATA_W-1];
	assign reg_cnt   = reg_right ? neg_b : operand_b;
	assign reg_big   = |reg_cnt[DATA_W-1:SHAMT_W];

	assign use_shi  = (func == OP_LSHI) || (func == OP_ASHI);
	assign sh_right = use_shi ? imm_byte[SHAMT_W] : reg_right;
	assign sh_big   = use_shi ? 1'b0 : reg_big;
	assign sh_amt   = use_shi ? imm_byte[SHAMT_W-1:0] : reg_cnt[SHAMT_W-1:0];

	assign fill    = {DATA_W{operand_a[DATA_W-1]}};
	assign shl_out = sh_big ? '0 : (operand_a << sh_amt);
	assign shr_out = sh_big ? '0 : (operand_a >> sh_amt);
	assign sar_out = sh_big ? fill : DATA_W'($signed(operand_a) >>> sh_amt);

	// next state select
	always_comb begin
		nxt = cur;
		unique case (func)
			OP_ADD, OP_ADDI: begin
				nxt.result = add_out;
				nxt.flags  = add_flags;
			end
			OP_SUB, OP_SUBI: begin
				nxt.result = sub_out;
				nxt.flags  = sub_flags;
			end
			OP_CMP, OP_CMPI: nxt.flags = sub_flags;
			OP_AND:  nxt.result = operand_a & operand_b;
			OP_ANDI: nxt.result = operand_a & imm_s;
			OP_OR:   nxt.result = operand_a | operand_b;
			OP_ORI:  nxt.result = operand_a | imm_z;
			OP_XOR:  nxt.result = operand_a ^ operand_b;
			OP_XORI: nxt.result = operand_a ^ imm_z;
			OP_MOV, OP_LOAD: nxt.result = operand_b;
			OP_MOVI: nxt.result = imm_z;
			OP_LSH, OP_LSHI: nxt.result = sh_right ? shr_out : shl_out;
			OP_ASH, OP_ASHI: nxt.result = sh_right ? sar_out : shl_out;
			OP_LUI:  nxt.result = {imm_byte, {(DATA_W-IMM_W){1'b0}}};
			OP_STOR: nxt.result = operand_a;
			default: nxt = cur;
		endcase
	end

endmodule

`default_nettype wire

[rtl/alu16_with_status_flags.sv]
// the result word is executed from the input register once the output slot is free or being drained
// throughput: one word per cycle while the output is not stalled, input register then execute into the result register
// the held result and flags update in the same cycle the result word is loaded,
// so each word sees the state left by the word before it
// reset clears the held result, the flags and both valid bits
`default_nettype none

module alu16_with_status_flags
	import alu16_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // func[4:0], operand_a[20:5], operand_b[36:21], imm_byte[44:37]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // result_value[15:0], flag_carry[16], flag_borrow[17],
	                                   // flag_overflow[18], flag_zero[19]
);

	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [DATA_W-1:0] a_s1;
	logic [DATA_W-1:0] b_s1;
	logic [IMM_W-1:0]  imm_s1;
	alu_state_t        state_q;
	alu_state_t        state_nxt;
	logic              m_valid_q;
	alu_state_t        m_data_q;
	logic              advance;

	// input stage moves on when the output slot is free or being drained
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tdata[4:0];
			a_s1    <= s_tdata[20:5];
			b_s1    <= s_tdata[36:21];
			imm_s1  <= s_tdata[44:37];
		end
	end

	alu16_exec u_exec (
		.func      (func_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.imm_byte  (imm_s1),
		.cur       (state_q),
		.nxt       (state_nxt)
	);

	// held result and status flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= state_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, m_data_q.flags.zero, m_data_q.flags.overflow,
		m_data_q.flags.borrow, m_data_q.flags.carry, m_data_q.result};

`ifndef SYNTHESIS
	// state must not move while a result word is stuck at the output
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> $stable(state_q))
		else $error("state changed while output stalled");

	// the word on the output always mirrors the held state
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q == state_q))
		else $error("output word differs from held state");

	// a word that executes always shows up at the output
	a_advance_valid: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("executed word lost");

	// a waiting input word is never dropped
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage word dropped");
`endif

endmodule

`default_nettype wire
